>>> sv/lwr_pkg.sv
// Shared constants, register codes and types of the lag watchdog restart unit.
package lwr_pkg;

  localparam int unsigned HISTORY_DEPTH   = 256;
  localparam int unsigned CHECK_PERIOD_MS = 60000;

  localparam int unsigned DUR_W      = 16;
  localparam int unsigned WC_W       = 9;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned TIMER_W    = 32;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned HIST_AW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W      = DUR_W + HIST_AW;
  localparam int unsigned DIV_STEP_W = $clog2(SUM_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'b1;

  localparam logic [TIMER_W-1:0] CHECK_PERIOD = TIMER_W'(CHECK_PERIOD_MS);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> sv/lwr_win_sum.sv
// Duration history ring and serial window summation, one entry per cycle.
module lwr_win_sum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [lwr_pkg::WC_W-1:0]          n,
  input  logic                              wr_en,
  input  logic [lwr_pkg::DUR_W-1:0]         wr_data,
  output lwr_pkg::unit_sts_t                sts,
  output logic [lwr_pkg::SUM_W-1:0]         sum,
  output logic [lwr_pkg::CNT_W-1:0]         stored
);

  logic [lwr_pkg::DUR_W-1:0]   mem [lwr_pkg::HISTORY_DEPTH];
  logic [lwr_pkg::HIST_AW-1:0] wp_r;
  logic [lwr_pkg::CNT_W-1:0]   stored_r;
  logic [lwr_pkg::HIST_AW-1:0] rd_addr_r;
  logic [lwr_pkg::CNT_W-1:0]   left_r;
  logic                        rd_vld_r;
  logic [lwr_pkg::DUR_W-1:0]   rd_data_r;
  logic [lwr_pkg::SUM_W-1:0]   acc_r;
  logic                        busy_r;
  logic                        done_r;
  logic                        rd_en;
  logic                        fin;

  localparam logic [lwr_pkg::HIST_AW-1:0] LAST = lwr_pkg::HIST_AW'(lwr_pkg::HISTORY_DEPTH - 1);

  assign rd_en = busy_r && (left_r != '0);
  assign fin   = busy_r && (left_r == '0) && !rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      stored_r <= '0;
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      left_r   <= '0;
      rd_addr_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (wr_en) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
        if (stored_r != lwr_pkg::CNT_W'(lwr_pkg::HISTORY_DEPTH)) begin
          stored_r <= stored_r + 1'b1;
        end
      end
      if (start) begin
        busy_r    <= 1'b1;
        left_r    <= lwr_pkg::CNT_W'(n);
        rd_addr_r <= (wp_r == '0) ? LAST : wp_r - 1'b1;
        rd_vld_r  <= 1'b0;
      end else if (busy_r) begin
        rd_vld_r <= rd_en;
        if (rd_en) begin
          left_r    <= left_r - 1'b1;
          rd_addr_r <= (rd_addr_r == '0) ? LAST : rd_addr_r - 1'b1;
        end
        if (fin) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r + lwr_pkg::SUM_W'(rd_data_r);
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sum      = acc_r;
  assign stored   = stored_r;

endmodule

>>> sv/lwr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module lwr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lwr_pkg::SUM_W-1:0] dividend,
  input  logic [lwr_pkg::WC_W-1:0]  divisor,
  output lwr_pkg::unit_sts_t        sts,
  output logic [lwr_pkg::SUM_W-1:0] quotient
);

  logic [lwr_pkg::SUM_W-1:0]      quo_r;
  logic [lwr_pkg::SUM_W-1:0]      quo_nxt;
  logic [lwr_pkg::WC_W-1:0]       rem_r;
  logic [lwr_pkg::WC_W-1:0]       rem_nxt;
  logic [lwr_pkg::WC_W:0]         trial;
  logic [lwr_pkg::WC_W:0]         diff;
  logic                           fit;
  logic [lwr_pkg::DIV_STEP_W-1:0] step_r;
  logic                           busy_r;
  logic                           done_r;

  always_comb begin
    trial   = {rem_r, quo_r[lwr_pkg::SUM_W-1]};
    diff    = trial - {1'b0, divisor};
    fit     = (trial >= {1'b0, divisor});
    rem_nxt = fit ? diff[lwr_pkg::WC_W-1:0] : trial[lwr_pkg::WC_W-1:0];
    quo_nxt = {quo_r[lwr_pkg::SUM_W-2:0], fit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= lwr_pkg::DIV_STEP_W'(lwr_pkg::SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == lwr_pkg::DIV_STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

>>> sv/lag_watchdog_restart_unit.sv
// Top level of the lag watchdog restart unit: timer, sequencing and result beat.
// Without a due check, an accepted input beat passes to the emit state and is
// then registered as the result beat. A due check with enough history adds
// serial history reads (one memory read port) and bit-serial division.
// A new input beat is taken only in idle, once the last result beat is emitted.
// Reset (rst_n low, synchronous) clears timer, ring pointer, fill count, config.
module lag_watchdog_restart_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lwr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lwr_pkg::DUR_W-1:0]      in_tick_duration,
  input  logic                           in_shutdown_pending,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_check_done,
  output logic                           out_average_valid,
  output logic [lwr_pkg::DUR_W-1:0]      out_average_duration,
  output logic                           out_restart_request
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [lwr_pkg::CFG_IDX_W-1:0] REG_WINDOW_COUNT_SEL = lwr_pkg::REG_WINDOW_COUNT;
  localparam logic [lwr_pkg::CFG_IDX_W-1:0] REG_THRESHOLD_SEL    = lwr_pkg::REG_THRESHOLD;

  logic [1:0]                     state_r;
  logic [1:0]                     state_nxt;
  logic [lwr_pkg::WC_W-1:0]       wc_r;
  logic [lwr_pkg::THR_W-1:0]      thr_r;
  logic [lwr_pkg::TIMER_W-1:0]    timer_r;
  logic [lwr_pkg::TIMER_W:0]      timer_add;
  logic [lwr_pkg::TIMER_W-1:0]    timer_sat;
  logic [lwr_pkg::DUR_W-1:0]      dur_r;
  logic                           sd_r;
  logic                           chk_r;
  logic                           vld_r;
  logic [lwr_pkg::DUR_W-1:0]      avg_r;
  logic                           rst_req_r;
  logic                           out_valid_r;
  logic                           out_chk_r;
  logic                           out_vld_r;
  logic [lwr_pkg::DUR_W-1:0]      out_avg_r;
  logic                           out_rst_r;

  logic                           accept;
  logic                           enabled;
  logic                           expire;
  logic                           enough;
  logic                           emit_go;
  logic                           sum_start;
  logic                           div_start;
  logic [lwr_pkg::DUR_W-1:0]      quo_avg;

  lwr_pkg::unit_sts_t             sum_sts;
  lwr_pkg::unit_sts_t             div_sts;
  logic [lwr_pkg::SUM_W-1:0]      win_sum;
  logic [lwr_pkg::CNT_W-1:0]      stored;
  logic [lwr_pkg::SUM_W-1:0]      quotient;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign enabled   = (wc_r != '0) && (thr_r != '0);
  assign timer_add = {1'b0, timer_r} + (lwr_pkg::TIMER_W + 1)'(in_tick_duration);
  assign timer_sat = timer_add[lwr_pkg::TIMER_W] ? '1 : timer_add[lwr_pkg::TIMER_W-1:0];
  assign expire    = (timer_sat >= lwr_pkg::CHECK_PERIOD);
  assign enough    = ({{lwr_pkg::WC_W{1'b0}}, stored} >= {{lwr_pkg::CNT_W{1'b0}}, wc_r});
  assign sum_start = accept && enabled && expire && enough;
  assign div_start = (state_r == ST_SUM) && sum_sts.done;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign quo_avg   = quotient[lwr_pkg::DUR_W-1:0];

  lwr_win_sum u_win_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sum_start),
    .n       (wc_r),
    .wr_en   (emit_go),
    .wr_data (dur_r),
    .sts     (sum_sts),
    .sum     (win_sum),
    .stored  (stored)
  );

  lwr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (win_sum),
    .divisor  (wc_r),
    .sts      (div_sts),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = sum_start ? ST_SUM : ST_EMIT;
        end
      end
      ST_SUM: begin
        if (sum_sts.done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wc_r        <= '0;
      thr_r       <= '0;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_COUNT_SEL: wc_r  <= cfg_wdata[lwr_pkg::WC_W-1:0];
          REG_THRESHOLD_SEL:    thr_r <= cfg_wdata[lwr_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (accept && enabled) begin
        timer_r <= expire ? '0 : timer_sat;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dur_r     <= in_tick_duration;
      sd_r      <= in_shutdown_pending;
      chk_r     <= enabled && expire;
      vld_r     <= 1'b0;
      avg_r     <= '0;
      rst_req_r <= 1'b0;
    end else if ((state_r == ST_DIV) && div_sts.done) begin
      vld_r     <= (quo_avg != '0);
      avg_r     <= quo_avg;
      rst_req_r <= (quo_avg != '0) && (quo_avg >= thr_r) && !sd_r;
    end
    if (emit_go) begin
      out_chk_r <= chk_r;
      out_vld_r <= vld_r;
      out_avg_r <= avg_r;
      out_rst_r <= rst_req_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_check_done       = out_chk_r;
  assign out_average_valid    = out_vld_r;
  assign out_average_duration = out_avg_r;
  assign out_restart_request  = out_rst_r;

`ifndef ASSERT_OFF
  a_restart_needs_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_rst_r || out_vld_r))
    else $error("restart request without valid average");

  a_avg_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_vld_r || out_chk_r))
    else $error("valid average without check");

  a_invalid_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vld_r) |-> (out_avg_r == '0))
    else $error("nonzero average while not valid");

  a_div_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> (state_r == ST_DIV))
    else $error("divider busy outside divide phase");
`endif

endmodule
